// ===== sv/fixed_point_alu_core_defines.svh =====
// Assertion macros for the fixed-point ALU.
`ifndef FIXED_POINT_ALU_CORE_DEFINES_SVH
`define FIXED_POINT_ALU_CORE_DEFINES_SVH

`define FPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fixed_point_alu_core check failed");

`define FPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fixed_point_alu_core check failed");

`endif

// ===== sv/fpa_pkg.sv =====
package fpa_pkg;
    localparam int CMD_W = 4;
    localparam int OPND_W = 32;
    localparam int WORD_BITS = 32;

    localparam logic [CMD_W-1:0] CMD_ADD = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 4'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 4'd3;
    localparam logic [CMD_W-1:0] CMD_MIN = 4'd4;
    localparam logic [CMD_W-1:0] CMD_MAX = 4'd5;
    localparam logic [CMD_W-1:0] CMD_INC = 4'd6;
    localparam logic [CMD_W-1:0] CMD_DEC = 4'd7;
    localparam logic [CMD_W-1:0] CMD_TO_INT = 4'd8;
    localparam logic [CMD_W-1:0] CMD_FROM_INT = 4'd9;
    localparam logic [CMD_W-1:0] CMD_SIGN = 4'd10;

    typedef struct packed {
        logic [OPND_W-1:0] value;
        logic              less;
        logic              equal;
        logic              greater;
        logic              dbz;
        logic              ovf;
    } res_t;
endpackage

// ===== sv/fpa_div_cell.sv =====
module fpa_div_cell #(
    parameter int NW = 64,
    parameter int DW = 33,
    parameter int QW = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          stall,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_quo,
    input  logic [DW-1:0] in_den,
    input  fpa_pkg::res_t in_side,
    input  logic          in_neg,
    input  logic          in_isdiv,
    output logic          out_valid,
    output logic [NW-1:0] out_num,
    output logic [DW-1:0] out_rem,
    output logic [QW-1:0] out_quo,
    output logic [DW-1:0] out_den,
    output fpa_pkg::res_t out_side,
    output logic          out_neg,
    output logic          out_isdiv
);
    import fpa_pkg::*;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    logic          valid_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    res_t          side_reg;
    logic          neg_reg;
    logic          isdiv_reg;

    assign trial = {in_rem, in_num[NW-1]};
    assign diff  = trial - {1'b0, in_den};
    assign take  = !diff[DW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            num_reg   <= {in_num[NW-2:0], 1'b0};
            rem_reg   <= take ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg   <= {in_quo[QW-2:0], take};
            den_reg   <= in_den;
            side_reg  <= in_side;
            neg_reg   <= in_neg;
            isdiv_reg <= in_isdiv;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;
    assign out_neg   = neg_reg;
    assign out_isdiv = isdiv_reg;
endmodule

// ===== sv/fixed_point_alu_core.sv =====
// One operation per cycle while not stalled. Results come from the front
// stage, the multiply stage and the chain of restoring-division cells, one
// quotient bit per cell, that every command passes through so results stay
// in order. Stall freezes the whole chain; the output register sits at the
// end. Min, max, add and the other simple commands are resolved in the front
// stage and ride the chain.
module fixed_point_alu_core #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [fpa_pkg::CMD_W-1:0]             command,
    input  logic signed [fpa_pkg::OPND_W-1:0]     operand_a,
    input  logic signed [fpa_pkg::OPND_W-1:0]     operand_b,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [fpa_pkg::OPND_W-1:0]     result_value,
    output logic                                  a_less,
    output logic                                  a_equal,
    output logic                                  a_greater,
    output logic                                  divide_by_zero,
    output logic                                  overflow
);
    import fpa_pkg::*;

    localparam int NW = OPND_W + FRACTION_BITS + 1;
    localparam int DW = OPND_W + 2;
    localparam int QW = NW;
    localparam int PW = 2 * OPND_W;
    localparam int WMAXW = WORD_BITS;

    logic stall;
    assign stall = out_valid && out_stall;
    assign in_stall = stall;

    // front stage
    logic [OPND_W-1:0] mag_a, mag_b;
    logic              neg_r;
    logic [OPND_W-1:0] quick;
    logic              lt, eq;
    logic [WORD_BITS-1:0] wa, wb, wsum;

    assign mag_a = operand_a[OPND_W-1] ? (~operand_a + 1'b1) : operand_a;
    assign mag_b = operand_b[OPND_W-1] ? (~operand_b + 1'b1) : operand_b;
    assign neg_r = operand_a[OPND_W-1] ^ operand_b[OPND_W-1];
    assign lt = operand_a < operand_b;
    assign eq = operand_a == operand_b;
    assign wa = WORD_BITS'(operand_a);
    assign wb = WORD_BITS'(operand_b);

    always_comb
    begin
        wsum = '0;
        quick = '0;
        case (command)
            CMD_ADD:
            begin
                wsum = wa + wb;
                quick = OPND_W'(wsum);
            end
            CMD_SUB:
            begin
                wsum = wa - wb;
                quick = OPND_W'(wsum);
            end
            CMD_MIN: quick = lt ? operand_a : operand_b;
            CMD_MAX: quick = lt ? operand_b : operand_a;
            CMD_INC:
            begin
                wsum = wa + 1'b1;
                quick = OPND_W'(wsum);
            end
            CMD_DEC:
            begin
                wsum = wa - 1'b1;
                quick = OPND_W'(wsum);
            end
            CMD_TO_INT: quick = operand_a >>> FRACTION_BITS;
            CMD_FROM_INT:
            begin
                wsum = wa << FRACTION_BITS;
                quick = OPND_W'(wsum);
            end
            CMD_SIGN: quick = operand_a[OPND_W-1] ? '1 :
                              ((operand_a != '0) ? OPND_W'(1) : '0);
            default: quick = '0;
        endcase
    end

    logic              s0_valid_reg;
    logic [OPND_W-1:0] s0_ma_reg, s0_mb_reg;
    logic [CMD_W-1:0]  s0_cmd_reg;
    res_t              s0_side_reg;
    logic              s0_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (!stall)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s0_ma_reg   <= mag_a;
            s0_mb_reg   <= mag_b;
            s0_cmd_reg  <= command;
            s0_neg_reg  <= neg_r;
            s0_side_reg <= '{value: quick, less: lt, equal: eq, greater: !lt && !eq,
                             dbz: (command == CMD_DIV) && (operand_b == '0), ovf: 1'b0};
        end
    end

    // multiply stage
    logic [PW-1:0] prod;
    assign prod = s0_ma_reg * s0_mb_reg;

    logic              s1_valid_reg;
    logic [PW-1:0]     s1_prod_reg;
    logic [OPND_W-1:0] s1_ma_reg, s1_mb_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    res_t              s1_side_reg;
    logic              s1_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!stall)
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s1_prod_reg <= prod;
            s1_ma_reg   <= s0_ma_reg;
            s1_mb_reg   <= s0_mb_reg;
            s1_cmd_reg  <= s0_cmd_reg;
            s1_side_reg <= s0_side_reg;
            s1_neg_reg  <= s0_neg_reg;
        end
    end

    // rounded product magnitude, carried through the chain in the quotient slot
    logic [PW:0]   prod_rnd;
    logic [PW:0]   prod_q;
    logic          is_div;
    logic [QW-1:0] quo0;
    assign prod_rnd = {1'b0, s1_prod_reg} + ((PW+1)'(1) << (FRACTION_BITS - 1));
    assign prod_q   = prod_rnd >> FRACTION_BITS;
    assign is_div   = (s1_cmd_reg == CMD_DIV) && !s1_side_reg.dbz;

    always_comb
    begin
        if (prod_q[PW:QW] != '0)
            quo0 = '1;
        else
            quo0 = prod_q[QW-1:0];
    end

    // dividend is twice the shifted magnitude: the chain yields floor(2n / d)
    logic [NW-1:0] num0;
    assign num0 = NW'({s1_ma_reg, (FRACTION_BITS+1)'(0)});

    logic          c_valid [0:NW];
    logic [NW-1:0] c_num   [0:NW];
    logic [DW-1:0] c_rem   [0:NW];
    logic [QW-1:0] c_quo   [0:NW];
    logic [DW-1:0] c_den   [0:NW];
    res_t          c_side  [0:NW];
    logic          c_neg   [0:NW];
    logic          c_isdiv [0:NW];

    res_t s1_side_m;
    always_comb
    begin
        s1_side_m = s1_side_reg;
        s1_side_m.ovf = (s1_cmd_reg == CMD_MUL);
    end

    assign c_valid[0] = s1_valid_reg;
    assign c_num[0]   = is_div ? num0 : '0;
    assign c_rem[0]   = '0;
    assign c_quo[0]   = is_div ? '0 : quo0;
    assign c_den[0]   = DW'(s1_mb_reg);
    assign c_side[0]  = s1_side_m;
    assign c_neg[0]   = s1_neg_reg;
    assign c_isdiv[0] = is_div;

    genvar gi;
    generate
        for (gi = 0; gi < NW; gi++)
        begin : g_cell
            logic          v_o, n_o, i_o;
            logic [NW-1:0] num_o;
            logic [DW-1:0] rem_o, den_o;
            logic [QW-1:0] quo_o;
            res_t          side_o;
            logic [DW-1:0] den_i;
            logic [QW-1:0] quo_i;
            logic [QW-1:0] pass_q;

            assign den_i = c_den[gi];
            assign quo_i = c_quo[gi];

            fpa_div_cell #(.NW(NW), .DW(DW), .QW(QW)) u_cell (
                .clk(clk), .rst_n(rst_n), .in_valid(c_valid[gi]), .stall(stall),
                .in_num(c_num[gi]), .in_rem(c_rem[gi]), .in_quo(quo_i),
                .in_den(den_i), .in_side(c_side[gi]), .in_neg(c_neg[gi]),
                .in_isdiv(c_isdiv[gi]),
                .out_valid(v_o), .out_num(num_o), .out_rem(rem_o), .out_quo(quo_o),
                .out_den(den_o), .out_side(side_o), .out_neg(n_o), .out_isdiv(i_o)
            );

            logic [QW-1:0] keep_reg;
            always_ff @(posedge clk)
            begin
                if (!stall)
                    keep_reg <= quo_i;
            end
            assign pass_q = i_o ? quo_o : keep_reg;

            assign c_valid[gi+1] = v_o;
            assign c_num[gi+1]   = num_o;
            assign c_rem[gi+1]   = rem_o;
            assign c_quo[gi+1]   = pass_q;
            assign c_den[gi+1]   = den_o;
            assign c_side[gi+1]  = side_o;
            assign c_neg[gi+1]   = n_o;
            assign c_isdiv[gi+1] = i_o;
        end
    endgenerate

    // round half away from zero: floor((2n + d) / 2d) = (floor(2n / d) + 1) >> 1
    logic [QW:0]        rq;
    logic [QW-1:0]      mag_q;
    logic [WMAXW-1:0]   lim;
    logic               sat;
    logic [WMAXW-1:0]   wres;
    res_t               last;
    res_t               fin;

    assign last = c_side[NW];
    assign rq   = {1'b0, c_quo[NW]} + (QW+1)'(1);
    assign mag_q = c_isdiv[NW] ? rq[QW:1] : c_quo[NW];
    assign lim  = {1'b0, {(WMAXW-1){1'b1}}};

    always_comb
    begin
        sat  = 1'b0;
        wres = '0;
        if (c_neg[NW])
        begin
            if (mag_q > QW'(lim) + QW'(1))
            begin
                sat  = 1'b1;
                wres = ~lim;
            end
            else
                wres = WMAXW'(~mag_q + 1'b1);
        end
        else
        begin
            if (mag_q > QW'(lim))
            begin
                sat  = 1'b1;
                wres = lim;
            end
            else
                wres = WMAXW'(mag_q);
        end
        fin = last;
        fin.ovf = 1'b0;
        if (c_isdiv[NW] || last.ovf)
        begin
            fin.value = OPND_W'(wres);
            fin.ovf   = sat;
        end
    end

    logic out_valid_reg;
    res_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!stall)
            out_valid_reg <= c_valid[NW];
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
            out_reg <= fin;
    end

    assign out_valid      = out_valid_reg;
    assign result_value   = out_reg.value;
    assign a_less         = out_reg.less;
    assign a_equal        = out_reg.equal;
    assign a_greater      = out_reg.greater;
    assign divide_by_zero = out_reg.dbz;
    assign overflow       = out_reg.ovf;
endmodule

// ===== sv/fpa_checker.sv =====
`include "fixed_point_alu_core_defines.svh"

module fpa_checker (
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic a_less,
    input logic a_equal,
    input logic a_greater,
    input logic divide_by_zero,
    input logic overflow,
    input logic [31:0] result_value
);
    `FPA_ASSERT_IMPL(a_cmp_onehot, clk, rst_n, out_valid, $onehot({a_less, a_equal, a_greater}))
    `FPA_ASSERT_IMPL(a_dbz_no_ovf, clk, rst_n, out_valid && divide_by_zero, !overflow)
    `FPA_ASSERT_IMPL(a_dbz_zero, clk, rst_n, out_valid && divide_by_zero, result_value == 32'd0)
    `FPA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(result_value))
    `FPA_ASSERT_IMPL(a_stall_link, clk, rst_n, in_stall, out_valid && out_stall)
endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .a_less(a_less), .a_equal(a_equal),
    .a_greater(a_greater), .divide_by_zero(divide_by_zero),
    .overflow(overflow), .result_value(result_value)
);
